/* rtl/core/prnu_pkg.sv */
// prnu_pkg: shared types and constants of the PageRank node update block.
// Depends on nothing; the divider, multiplier and top level import it.
package prnu_pkg;

    localparam int unsigned SUM_BITS   = 48;
    localparam int unsigned ALPHA_BITS = 16;
    localparam int unsigned NDOCS_BITS = 21;
    localparam int unsigned TOTAL_BITS = SUM_BITS + 2;
    localparam int unsigned ADDR_BITS  = 3;
    localparam int unsigned DATA_BITS  = 32;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd55705;
    localparam logic [NDOCS_BITS-1:0] NDOCS_RESET = 21'd1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX     = {SUM_BITS{1'b1}};

    // Register index, taken from address bit 2.
    typedef enum logic {
        REG_ALPHA    = 1'b0,
        REG_NUM_DOCS = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_LINK,
        S_DIV_BASE,
        S_MUL_SUM,
        S_MUL_OWN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

endpackage

/* rtl/core/prnu_div.sv */
// prnu_div: restoring divider, one quotient bit per cycle.
// Depends on prnu_pkg (unit_ctl_t).
module prnu_div #(
    parameter int unsigned NUM_W = 33,
    parameter int unsigned DEN_W = 21
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output prnu_pkg::unit_ctl_t ctl,
    output logic [NUM_W-1:0]    quot
);
    import prnu_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign ge        = (rem_shift >= {1'b0, den_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign quot      = quo_reg;

endmodule

/* rtl/core/prnu_mul.sv */
// prnu_mul: shift-add multiplier giving floor(a * x / 2^16), one bit of a per cycle.
// Depends on prnu_pkg (ALPHA_BITS, unit_ctl_t).
module prnu_mul #(
    parameter int unsigned X_W = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [prnu_pkg::ALPHA_BITS-1:0] a,
    input  logic [X_W-1:0]                x,
    output prnu_pkg::unit_ctl_t           ctl,
    output logic [X_W-1:0]                prod
);
    import prnu_pkg::*;

    localparam int unsigned CNT_W = $clog2(ALPHA_BITS + 1);

    logic [ALPHA_BITS-1:0] a_reg, a_next;
    logic [X_W-1:0]        x_reg;
    logic [X_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [X_W:0]          sum;

    // The running value stays below x, so the sum fits one extra bit.
    assign sum = {1'b0, acc_reg} + (a_reg[0] ? {1'b0, x_reg} : '0);

    always_comb begin
        a_next    = a_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            acc_next  = '0;
            cnt_next  = CNT_W'(ALPHA_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = sum[X_W:1];
            a_next   = a_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
        if (start) begin
            x_reg <= x;
        end
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign prod      = acc_reg;

endmodule

/* rtl/core/pagerank_node_update.sv */
// pagerank_node_update: top level of the PageRank node update block.
// Depends on prnu_pkg, prnu_div and prnu_mul.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | one in-link of the document being updated
//  m_      | out       | m_valid / m_ready  | new rank and saturation flag
//  apb     | in        | psel/penable/pready| alpha at 0x0, num_docs at 0x4
//
// Steps: an in-link with non-zero degree goes through the bit-serial divider; an item
// with no link or zero degree skips the divider. The last item adds the teleport division,
// the alpha * sum multiply, a second multiply when the document has no out-links, and
// the load of the output register.
// Reset is synchronous on aresetn low; alpha returns to 55705 and num_docs to 1.
// The result sits in an output register, so a stall on m_ready holds only the finish
// step of the next document; no in-links are taken while that step waits.
module pagerank_node_update #(
    parameter int unsigned RANK_BITS   = 32,
    parameter int unsigned DEGREE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_link_valid,
    input  logic [RANK_BITS-1:0]           s_neighbor_prev_rank,
    input  logic [DEGREE_BITS-1:0]         s_neighbor_out_degree,
    input  logic [RANK_BITS-1:0]           s_own_prev_rank,
    input  logic                           s_own_no_out_links,
    input  logic                           s_last,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [RANK_BITS-1:0]           m_new_rank,
    output logic                           m_saturated,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prnu_pkg::ADDR_BITS-1:0] paddr,
    input  logic [prnu_pkg::DATA_BITS-1:0] pwdata,
    output logic [prnu_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import prnu_pkg::*;

    // The divider serves both the in-link quotients and the teleport term.
    localparam int unsigned NUM_W = RANK_BITS + 1;
    localparam int unsigned DEN_W = (DEGREE_BITS > NDOCS_BITS) ? DEGREE_BITS : NDOCS_BITS;

    state_t state_reg, state_next;

    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [NDOCS_BITS-1:0] num_docs_reg;

    logic                  last_reg;
    logic                  own_nol_reg;
    logic [RANK_BITS-1:0]  own_rank_reg;
    logic [SUM_BITS-1:0]   link_sum_reg, link_sum_next;
    logic                  sum_clip_reg, sum_clip_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;

    logic                  m_valid_reg, m_valid_next;
    logic [RANK_BITS-1:0]  m_new_rank_reg;
    logic                  m_saturated_reg;

    logic                  s_fire;
    logic                  cfg_write;
    logic                  out_free;
    logic                  link_live;
    logic                  over;

    // divider and multiplier hook-up
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [NUM_W-1:0]      div_quot;
    unit_ctl_t             div_ctl;
    logic                  mul_start;
    logic [SUM_BITS-1:0]   mul_x;
    logic [SUM_BITS-1:0]   mul_prod;
    unit_ctl_t             mul_ctl;

    logic [ALPHA_BITS:0]   teleport;
    logic [NDOCS_BITS-1:0] docs_eff;
    logic [SUM_BITS:0]     sum_wide;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign link_live = s_link_valid && (s_neighbor_out_degree != '0);

    // Teleport numerator: (2^16 - alpha) scaled up to the rank's fraction width.
    assign teleport = (ALPHA_BITS + 1)'(1 << ALPHA_BITS) - {1'b0, alpha_reg};
    assign docs_eff = (num_docs_reg == '0) ? NDOCS_RESET : num_docs_reg;

    // ---------------------------------------------------------------
    // Configuration port: zero-wait, written in the access phase.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= ALPHA_RESET;
            num_docs_reg <= NDOCS_RESET;
        end else if (cfg_write) begin
            case (reg_idx_t'(paddr[2]))
                REG_ALPHA:    alpha_reg    <= pwdata[ALPHA_BITS-1:0];
                REG_NUM_DOCS: num_docs_reg <= pwdata[NDOCS_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_ALPHA:    prdata = DATA_BITS'(alpha_reg);
            REG_NUM_DOCS: prdata = DATA_BITS'(num_docs_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (link_live) begin
                        state_next = S_DIV_LINK;
                    end else if (s_last) begin
                        state_next = S_DIV_BASE;
                    end
                end
            end
            S_DIV_LINK: begin
                if (div_ctl.done) begin
                    state_next = last_reg ? S_DIV_BASE : S_IDLE;
                end
            end
            S_DIV_BASE: begin
                if (div_ctl.done) begin
                    state_next = S_MUL_SUM;
                end
            end
            S_MUL_SUM: begin
                if (mul_ctl.done) begin
                    state_next = own_nol_reg ? S_MUL_OWN : S_FINISH;
                end
            end
            S_MUL_OWN: begin
                if (mul_ctl.done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: unit starts and operand selection
    // ---------------------------------------------------------------
    always_comb begin
        div_start = 1'b0;
        div_num   = NUM_W'(teleport) << (RANK_BITS - ALPHA_BITS);
        div_den   = DEN_W'(docs_eff);
        mul_start = 1'b0;
        mul_x     = link_sum_next;
        case (state_reg)
            S_IDLE: begin
                if (s_fire && link_live) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(s_neighbor_prev_rank);
                    div_den   = DEN_W'(s_neighbor_out_degree);
                end else if (s_fire && s_last) begin
                    div_start = 1'b1;
                end
            end
            S_DIV_LINK: begin
                div_start = div_ctl.done && last_reg;
            end
            S_DIV_BASE: begin
                mul_start = div_ctl.done;
            end
            S_MUL_SUM: begin
                mul_start = mul_ctl.done && own_nol_reg;
                mul_x     = SUM_BITS'(own_rank_reg);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath: running sum, total and output register
    // ---------------------------------------------------------------
    assign sum_wide = {1'b0, link_sum_reg} + (SUM_BITS + 1)'(div_quot);
    assign over     = (total_reg[TOTAL_BITS-1:RANK_BITS] != '0);

    always_comb begin
        link_sum_next = link_sum_reg;
        sum_clip_next = sum_clip_reg;
        total_next    = total_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            S_DIV_LINK: begin
                // saturating add of the in-link quotient
                if (div_ctl.done) begin
                    if (sum_wide[SUM_BITS]) begin
                        link_sum_next = SUM_MAX;
                        sum_clip_next = 1'b1;
                    end else begin
                        link_sum_next = sum_wide[SUM_BITS-1:0];
                    end
                end
            end
            S_DIV_BASE: begin
                if (div_ctl.done) begin
                    total_next = TOTAL_BITS'(div_quot);
                end
            end
            S_MUL_SUM, S_MUL_OWN: begin
                if (mul_ctl.done) begin
                    total_next = total_reg + TOTAL_BITS'(mul_prod);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    link_sum_next = '0;
                    sum_clip_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            link_sum_reg <= '0;
            sum_clip_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            link_sum_reg <= link_sum_next;
            sum_clip_reg <= sum_clip_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        if (s_fire) begin
            last_reg     <= s_last;
            own_nol_reg  <= s_own_no_out_links;
            own_rank_reg <= s_own_prev_rank;
        end
        if (state_reg == S_FINISH && out_free) begin
            // clip to all ones
            m_new_rank_reg  <= over ? {RANK_BITS{1'b1}} : total_reg[RANK_BITS-1:0];
            m_saturated_reg <= over || sum_clip_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_rank  = m_new_rank_reg;
    assign m_saturated = m_saturated_reg;

    prnu_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .ctl     (div_ctl),
        .quot    (div_quot)
    );

    prnu_mul #(
        .X_W (SUM_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (alpha_reg),
        .x       (mul_x),
        .ctl     (mul_ctl),
        .prod    (mul_prod)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_clip_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_clip_reg |-> (link_sum_reg == SUM_MAX))
        else $error("sticky clip set while running sum is not full");

    a_div_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.done |-> (state_reg == S_DIV_LINK || state_reg == S_DIV_BASE))
        else $error("divider finished outside a division step");

    a_mul_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_ctl.done |-> (state_reg == S_MUL_SUM || state_reg == S_MUL_OWN))
        else $error("multiplier finished outside a multiply step");

    a_empty_item_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_last && !link_live) |=> (state_reg == S_IDLE))
        else $error("item without contribution did not return to idle");

endmodule
